FILE: rtl/hla_pkg.sv
// hla_pkg: widths and constants of the hyperperiod lcm accumulator
// no dependencies; imported by hyperperiod_lcm_accumulator
package hla_pkg;

  localparam int MultW     = 63;
  localparam int AluW      = MultW + 2;
  localparam int CntW      = 6;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 64;
  localparam int OutTuserW = 2;

  localparam logic [MultW-1:0] MultMax = {MultW{1'b1}};
  localparam logic [MultW-1:0] MultOne = {{(MultW-1){1'b0}}, 1'b1};

  // bit positions inside the output tuser
  localparam int TuserOvf = 0;
  localparam int TuserClr = 1;

endpackage

FILE: rtl/hyperperiod_lcm_accumulator.sv
// hyperperiod_lcm_accumulator: running lcm of stream intervals with saturation
// depends on hla_pkg (widths and constants)
//
// usage: intervals arrive on the s_axis channel, one per transfer; tlast marks
// the final interval of a set and tuser carries the rebuild request, which is
// only looked at together with tlast. each interval is folded into a running
// multiple (reset value 1) as acc / gcd(acc, interval) * interval.
// on the last interval one result transfer leaves on m_axis: the hyperperiod,
// the sticky overflow flag and the echoed rebuild request. the running
// multiple and the overflow flag then return to their reset values.
// arithmetic: one shared 65-bit add/subtract unit does all of it. a binary
// gcd takes one shift, swap or subtract per cycle; the multiple is then
// divided by the gcd (restoring division) and the quotient is multiplied by
// the interval (msb-first shift-add). a zero interval or zero multiple goes
// straight to the final step.
// s_axis_tready is high only while no item is in work.
// reset clears the multiple to 1, the overflow flag and the output valid flag.
// a stalled receiver only blocks the final step of a last item: the result
// waits in the output register and other intervals are still taken.
module hyperperiod_lcm_accumulator #(
  parameter int INTERVAL_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hla_pkg::InTdataW-1:0]   s_axis_tdata,   // [31:0] interval_ns
  input  logic                           s_axis_tlast,   // last
  input  logic                           s_axis_tuser,   // rebuild
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hla_pkg::OutTdataW-1:0]  m_axis_tdata,   // [62:0] hyperperiod_ns, [63] zero
  output logic [hla_pkg::OutTuserW-1:0]  m_axis_tuser    // [0] overflow, [1] clear_config
);
  import hla_pkg::*;

  localparam int IW = (INTERVAL_BITS < InTdataW) ? INTERVAL_BITS : InTdataW;
  localparam int KW = (IW > 1) ? $clog2(IW) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGcd  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [MultW-1:0] acc_q, acc_d;
  logic             ovf_q, ovf_d;
  logic [MultW-1:0] u_q, u_d;
  logic [MultW-1:0] v_q, v_d;
  logic [MultW-1:0] rem_q, rem_d;
  logic [IW-1:0]    iv_q, iv_d;
  logic [KW-1:0]    k_q, k_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             rebuild_q, rebuild_d;

  logic             out_valid_q, out_valid_d;
  logic [MultW-1:0] out_hp_q, out_hp_d;
  logic             out_ovf_q, out_ovf_d;
  logic             out_clr_q, out_clr_d;

  logic [IW-1:0]    iv_in;
  logic [MultW-1:0] rem_sh;
  logic [AluW-1:0]  alu_a, alu_b, alu_sum;
  logic             alu_sub;
  logic             s_fire;

  assign iv_in  = s_axis_tdata[IW-1:0];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign rem_sh = {rem_q[MultW-2:0], u_q[MultW-1]};

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_hp_q};
  assign m_axis_tuser  = {out_clr_q, out_ovf_q};

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      StGcd: begin
        alu_a   = {2'b00, u_q};
        alu_b   = {2'b00, v_q};
        alu_sub = 1'b1;
      end
      StDiv: begin
        alu_a   = {2'b00, rem_sh};
        alu_b   = {2'b00, v_q};
        alu_sub = 1'b1;
      end
      StMul: begin
        alu_a   = {1'b0, rem_q, 1'b0};
        alu_b   = iv_q[IW-1] ? {2'b00, u_q} : '0;
        alu_sub = 1'b0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(AluW-1){1'b0}}, alu_sub};
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    u_d         = u_q;
    v_d         = v_q;
    rem_d       = rem_q;
    iv_d        = iv_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    rebuild_d   = rebuild_q;
    out_valid_d = out_valid_q;
    out_hp_d    = out_hp_q;
    out_ovf_d   = out_ovf_q;
    out_clr_d   = out_clr_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_fire) begin
          last_d    = s_axis_tlast;
          rebuild_d = s_axis_tuser;
          iv_d      = iv_in;
          u_d       = acc_q;
          v_d       = {{(MultW-IW){1'b0}}, iv_in};
          k_d       = '0;
          if (iv_in == '0 || acc_q == '0) begin
            acc_d   = '0;
            state_d = StDone;
          end else begin
            state_d = StGcd;
          end
        end
      end
      StGcd: begin
        if (v_q == '0) begin
          // gcd found: divisor = u << k, dividend restarts from the multiple
          v_d     = u_q << k_q;
          u_d     = acc_q;
          rem_d   = '0;
          cnt_d   = CntW'(MultW - 1);
          state_d = StDiv;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!alu_sum[AluW-1]) begin
          // both odd and u >= v
          u_d = v_q;
          v_d = alu_sum[MultW-1:0];
        end else begin
          u_d = v_q;
          v_d = u_q;
        end
      end
      StDiv: begin
        // restoring division, quotient shifts into u
        if (!alu_sum[AluW-1]) begin
          rem_d = alu_sum[MultW-1:0];
        end else begin
          rem_d = rem_sh;
        end
        u_d = {u_q[MultW-2:0], ~alu_sum[AluW-1]};
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CntW'(IW - 1);
          state_d = StMul;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StMul: begin
        // msb-first shift-add; partial products only grow
        if (alu_sum[AluW-1:AluW-2] != 2'b00) begin
          acc_d   = MultMax;
          ovf_d   = 1'b1;
          state_d = StDone;
        end else begin
          rem_d = alu_sum[MultW-1:0];
          iv_d  = iv_q << 1;
          if (cnt_q == '0) begin
            acc_d   = alu_sum[MultW-1:0];
            state_d = StDone;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      StDone: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_hp_d    = acc_q;
          out_ovf_d   = ovf_q;
          out_clr_d   = rebuild_q;
          acc_d       = MultOne;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= MultOne;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    v_q       <= v_d;
    rem_q     <= rem_d;
    iv_q      <= iv_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    rebuild_q <= rebuild_d;
    out_hp_q  <= out_hp_d;
    out_ovf_q <= out_ovf_d;
    out_clr_q <= out_clr_d;
  end

  // divisor never zero while dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (v_q != '0))
    else $error("divisor is zero during division");

  // gcd operand u stays nonzero through the loop
  a_gcd_u_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGcd) |-> (u_q != '0))
    else $error("gcd operand u became zero");

  // issuing a result restores the running state
  a_result_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (acc_q == MultOne) && !ovf_q && (state_q == StIdle))
    else $error("running state not restored after result");

  // no input taken while an item is being worked on
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready)
    else $error("ready raised while busy");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench for hyperperiod_lcm_accumulator: streams interval sets, predicts the
// saturating running lcm per set and checks every hyperperiod transfer
// depends on hla_pkg and the hyperperiod_lcm_accumulator rtl
module testbench;
  import hla_pkg::*;

  localparam int IntervalBits  = 32;
  localparam int ItemTarget    = 1450;
  localparam int QuietItems    = 150;
  localparam int HoldCycles    = 600;
  localparam int WatchdogLimit = 8000;
  localparam int TailCycles    = 500;

  typedef struct packed {
    logic [MultW-1:0] hyperperiod;
    logic             overflow;
    logic             clear_config;
  } hyperperiod_result_t;

  class lcm_scoreboard;
    logic [MultW-1:0]    multiple;
    bit                  saturated;
    hyperperiod_result_t expected_periods[$];
    int                  failures;
    int                  reported;

    function new();
      multiple  = MultOne;
      saturated = 1'b0;
      failures  = 0;
      reported  = 0;
    endfunction

    function int outstanding();
      return expected_periods.size();
    endfunction

    // fold one accepted interval into the running multiple
    function void note_interval(logic [InTdataW-1:0] raw, logic lst, logic rb);
      longint unsigned ivl, acc, a, b, r, q, cap;
      hyperperiod_result_t res;
      cap = MultMax;
      ivl = raw & ((64'd1 << IntervalBits) - 64'd1);
      acc = multiple;
      if (ivl == 0 || acc == 0) begin
        acc = 0;
      end else begin
        a = acc;
        b = ivl;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        q = acc / a;
        if (q > cap / ivl) begin
          acc = cap;
          saturated = 1'b1;
        end else begin
          acc = q * ivl;
        end
      end
      multiple = acc[MultW-1:0];
      if (lst) begin
        res.hyperperiod  = multiple;
        res.overflow     = saturated;
        res.clear_config = rb;
        expected_periods.insert(expected_periods.size(), res);
        multiple  = MultOne;
        saturated = 1'b0;
      end
    endfunction

    function void check_result(logic [OutTdataW-1:0] data, logic [OutTuserW-1:0] flags);
      hyperperiod_result_t res;
      if (expected_periods.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: tdata 0x%016h tuser %02b", data, flags);
        end
        return;
      end
      res = expected_periods.pop_front();
      if (data[MultW-1:0] !== res.hyperperiod || data[OutTdataW-1:MultW] !== '0 ||
          flags[TuserOvf] !== res.overflow || flags[TuserClr] !== res.clear_config) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: exp hp %0d ovf %0b clr %0b, got tdata 0x%016h ovf %0b clr %0b",
                   res.hyperperiod, res.overflow, res.clear_config, data,
                   flags[TuserOvf], flags[TuserClr]);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;   // [31:0] interval_ns
  logic                 s_axis_tlast = 1'b0; // last
  logic                 s_axis_tuser = 1'b0; // rebuild
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // [62:0] hyperperiod_ns, [63] zero
  logic [OutTuserW-1:0] m_axis_tuser;        // [0] overflow, [1] clear_config

  lcm_scoreboard board = new();
  bit quiet = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;
  int stall_cycles = 0;

  hyperperiod_lcm_accumulator #(.INTERVAL_BITS(IntervalBits)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // any transfer on either side resets the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random back-pressure bursts plus one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic send_interval(input logic [InTdataW-1:0] ivl, input logic lst,
                               input logic rb);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ivl;
    s_axis_tlast  <= lst;
    s_axis_tuser  <= rb;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_interval(ivl, lst, rb);
    sent++;
  endtask

  // mostly small periods so sets survive several items, with some wide ones
  function automatic logic [InTdataW-1:0] pick_interval();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 40) return InTdataW'($urandom_range(1, 64));
    if (sel < 60) return InTdataW'($urandom_range(1, 1000));
    if (sel < 75) return InTdataW'(1) << $urandom_range(0, InTdataW - 1);
    if (sel < 92) return $urandom;
    return 32'hFFFF_FFFF - InTdataW'($urandom_range(0, 255));
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) begin
      send_interval(pick_interval(), i == len - 1, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-item sets at the field extremes, rebuild echoed
    send_interval(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_interval(32'h0000_0000, 1'b1, 1'b0);
    send_interval(32'h0000_0001, 1'b1, 1'b1);
    send_interval(32'h8000_0000, 1'b1, 1'b0);
    // rebuild on an inner item is ignored
    send_interval(32'd12, 1'b0, 1'b1);
    send_interval(32'd18, 1'b1, 1'b0);
    // zero interval in the middle of a set sticks
    send_interval(32'd6, 1'b0, 1'b0);
    send_interval(32'd0, 1'b0, 1'b1);
    send_interval(32'd35, 1'b1, 1'b1);
    // lands exactly on 2^63-1 without saturating
    send_interval(32'd454279, 1'b0, 1'b0);
    send_interval(32'd31252369, 1'b0, 1'b0);
    send_interval(32'd649657, 1'b1, 1'b0);
    // same again, then one more factor pushes it over
    send_interval(32'd454279, 1'b0, 1'b0);
    send_interval(32'd31252369, 1'b0, 1'b0);
    send_interval(32'd649657, 1'b0, 1'b0);
    send_interval(32'd2, 1'b1, 1'b1);
    // saturate, keep folding, then zero: overflow stays set
    send_interval(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_interval(32'hFFFF_FFFB, 1'b0, 1'b0);
    send_interval(32'hFFFF_FFF1, 1'b0, 1'b0);
    send_interval(32'd3, 1'b0, 1'b0);
    send_interval(32'd0, 1'b1, 1'b0);
    // a fresh set after overflow starts clean
    send_interval(32'd5, 1'b1, 1'b0);

    while (sent < ItemTarget) begin
      if (sent >= ItemTarget - QuietItems) quiet = 1'b1;
      calm = ($urandom_range(0, 3) == 0);
      if (!held && sent >= 400) begin
        // receiver holds off while short sets keep coming
        held     = 1'b1;
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (12) send_set($urandom_range(1, 2));
      end
      if (!drained && sent >= 800) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk_i);
      end
      send_set(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6));
    end
    s_axis_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
